/* rtl/sob_pkg.sv */
// ----------------------------------------------------------------------------
// sob_pkg
// Shared widths, types, codes and helpers for the sphere/box overlap test.
// ----------------------------------------------------------------------------
package sob_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int EXT_WIDTH   = COORD_WIDTH - 1;
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH   = SQ_WIDTH + 2;

  localparam logic FUNC_HOLD    = 1'b0;
  localparam logic FUNC_TEST    = 1'b1;
  localparam logic SHAPE_SPHERE = 1'b0;
  localparam logic SHAPE_BOX    = 1'b1;

  localparam logic [1:0] KIND_SS = 2'd0;
  localparam logic [1:0] KIND_SB = 2'd1;
  localparam logic [1:0] KIND_BS = 2'd2;
  localparam logic [1:0] KIND_BB = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [EXT_WIDTH-1:0]          ext_t;
  typedef logic [COORD_WIDTH-1:0]        dist_t;
  typedef logic [SQ_WIDTH-1:0]           sq_t;
  typedef logic [SUM_WIDTH-1:0]          sum_t;

  // One pair to test. Object a is the sphere whenever exactly one sphere is
  // involved; b is then the box.
  typedef struct packed {
    logic [1:0]   kind;
    coord_t [2:0] ca;
    coord_t [2:0] cb;
    ext_t [2:0]   ea;
    ext_t [2:0]   eb;
  } job_t;

  function automatic dist_t abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_WIDTH:0] d;
    d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    return d[COORD_WIDTH] ? dist_t'(-d) : d[COORD_WIDTH-1:0];
  endfunction

endpackage

/* rtl/sob_obj_if.sv */
// ----------------------------------------------------------------------------
// sob_obj_if
// Object channel: valid/ready handshake with one sphere or box object.
// ----------------------------------------------------------------------------
interface sob_obj_if
  import sob_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   func;
  logic   shape;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  ext_t   extent_x;
  ext_t   extent_y;
  ext_t   extent_z;

  modport source (
    output valid, func, shape, center_x, center_y, center_z,
           extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, func, shape, center_x, center_y, center_z,
           extent_x, extent_y, extent_z,
    output ready
  );
endinterface

/* rtl/sob_res_if.sv */
// ----------------------------------------------------------------------------
// sob_res_if
// Result channel: valid/ready handshake with the overlap verdict.
// ----------------------------------------------------------------------------
interface sob_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] pair_kind;

  modport source (output valid, hit, pair_kind, input ready);
  modport sink   (input valid, hit, pair_kind, output ready);
endinterface

/* rtl/sob_front.sv */
// ----------------------------------------------------------------------------
// sob_front
// Accepts objects, holds the first of a pair and builds a job for each test.
// ----------------------------------------------------------------------------
module sob_front
  import sob_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sob_obj_if.sink   obj_in,
  output logic      job_valid,
  input  logic      job_ready,
  output job_t      job
);

  logic         held_shape;
  coord_t [2:0] held_center;
  ext_t [2:0]   held_extent;

  coord_t [2:0] new_center;
  ext_t [2:0]   new_extent;
  logic         take;

  assign new_center = {obj_in.center_z, obj_in.center_y, obj_in.center_x};
  assign new_extent = {obj_in.extent_z, obj_in.extent_y, obj_in.extent_x};

  assign obj_in.ready = job_ready;
  assign take         = obj_in.valid && obj_in.ready;
  assign job_valid    = obj_in.valid && (obj_in.func == FUNC_TEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_shape  <= SHAPE_SPHERE;
      held_center <= '0;
      held_extent <= '0;
    end else if (take && obj_in.func == FUNC_HOLD) begin
      held_shape  <= obj_in.shape;
      held_center <= new_center;
      held_extent <= new_extent;
    end
  end

  // held box vs new sphere: swap so the sphere sits in slot a
  always_comb begin
    job.kind = {held_shape, obj_in.shape};
    if (job.kind == KIND_BS) begin
      job.ca = new_center;
      job.ea = new_extent;
      job.cb = held_center;
      job.eb = held_extent;
    end else begin
      job.ca = held_center;
      job.ea = held_extent;
      job.cb = new_center;
      job.eb = new_extent;
    end
  end

endmodule

/* rtl/sob_queue.sv */
// ----------------------------------------------------------------------------
// sob_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module sob_queue
  import sob_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/sob_back.sv */
// ----------------------------------------------------------------------------
// sob_back
// Five-stage overlap pipeline: distances, clamping, squares, sum, compare.
// ----------------------------------------------------------------------------
module sob_back
  import sob_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  sob_res_if.source res_out
);

  logic adv;

  logic        v1, v2, v3, v4;
  logic [1:0]  k1, k2, k3, k4;
  dist_t [2:0] s1_a;
  dist_t [2:0] s1_esum;
  dist_t [2:0] s1_be;
  dist_t       s1_rad;
  dist_t [2:0] s2_d;
  dist_t       s2_rad;
  logic        s2_bb;
  sq_t [2:0]   s3_sq;
  sq_t         s3_rsq;
  logic        s3_bb;
  sum_t        s4_sum;
  sq_t         s4_rsq;
  logic        s4_bb;

  dist_t [2:0] d_next;
  logic  [2:0] sep;

  // whole pipeline moves together; the last stage is the output register
  assign adv       = !res_out.valid || res_out.ready;
  assign job_ready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // distance from sphere centre to box along one axis, zero inside; centre to centre for two spheres
      if (k1 == KIND_SS) begin
        d_next[i] = s1_a[i];
      end else if (s1_a[i] > s1_be[i]) begin
        d_next[i] = s1_a[i] - s1_be[i];
      end else begin
        d_next[i] = '0;
      end
      sep[i] = s1_a[i] > s1_esum[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1     <= job.kind;
      s1_rad <= (job.kind == KIND_SS) ? dist_t'(job.ea[0]) + dist_t'(job.eb[0])
                                      : dist_t'(job.ea[0]);
      for (int i = 0; i < 3; i++) begin
        s1_a[i]    <= abs_diff(job.ca[i], job.cb[i]);
        s1_esum[i] <= dist_t'(job.ea[i]) + dist_t'(job.eb[i]);
        s1_be[i]   <= dist_t'(job.eb[i]);
      end

      k2     <= k1;
      s2_d   <= d_next;
      s2_rad <= s1_rad;
      s2_bb  <= ~|sep;

      k3     <= k2;
      s3_bb  <= s2_bb;
      s3_rsq <= sq_t'(s2_rad) * sq_t'(s2_rad);
      for (int i = 0; i < 3; i++) begin
        s3_sq[i] <= sq_t'(s2_d[i]) * sq_t'(s2_d[i]);
      end

      k4     <= k3;
      s4_bb  <= s3_bb;
      s4_rsq <= s3_rsq;
      s4_sum <= sum_t'(s3_sq[0]) + sum_t'(s3_sq[1]) + sum_t'(s3_sq[2]);

      res_out.pair_kind <= k4;
      res_out.hit       <= (k4 == KIND_BB) ? s4_bb : (s4_sum <= sum_t'(s4_rsq));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      res_out.valid <= 1'b0;
    end else if (adv) begin
      v1            <= job_valid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      res_out.valid <= v4;
    end
  end

endmodule

/* rtl/sphere_box_overlap_test.sv */
// ----------------------------------------------------------------------------
// sphere_box_overlap_test
// Narrow-phase overlap test of a sphere or axis-aligned box against another.
// ----------------------------------------------------------------------------
// Objects arrive on obj_in, one per cycle at full rate while the queue has
// room. An object with func low is held; each object with func high is tested
// against the held one and gives one result (hit, pair_kind) on res_out. The
// held object stays until the next func-low object, so many objects can be
// tested against one. The front builds a job per test into a two-entry queue;
// the back is a five-stage pipeline whose squaring stage (four 24x24
// multipliers) sets the cycle time. Stalls on res_out freeze the pipeline;
// the queue keeps obj_in moving until it fills.
module sphere_box_overlap_test
  import sob_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sob_obj_if.sink   obj_in,
  sob_res_if.source res_out
);

  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  sob_front u_front (
    .clk       (clk),
    .rst       (rst),
    .obj_in    (obj_in),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_data)
  );

  sob_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sob_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_data),
    .res_out   (res_out)
  );

endmodule
